// ----- hdl/bitmap_store_with_ack_defines.svh -----
// ---------------------------------------------------------------------------
// Bitmap store assertion macros
// Shared concurrent assertion forms, clocked on clk_i and off during reset.
// ---------------------------------------------------------------------------
`ifndef BITMAP_STORE_WITH_ACK_DEFINES_SVH
`define BITMAP_STORE_WITH_ACK_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BMS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bitmap store assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BMS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bitmap store assertion failed");

`endif

// ----- hdl/bms_pkg.sv -----
// ---------------------------------------------------------------------------
// Bitmap store package
// Widths, operation codes and defaults shared by the bitmap store modules.
// ---------------------------------------------------------------------------
`default_nettype none

package bms_pkg;

  localparam int NUM_WORDS_DEF = 4096;
  localparam int WORD_W        = 64;
  localparam int POS_W         = 6;
  localparam int FUNC_W        = 3;
  localparam int WIDX_W        = 12;
  localparam int BIDX_W        = 18;

  typedef logic [WORD_W-1:0] word_t;

  localparam logic [FUNC_W-1:0] FUNC_TEST  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_SET   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_FLIP  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_ACK   = 3'd4;

endpackage

`default_nettype wire

// ----- hdl/bms_ram.sv -----
// ---------------------------------------------------------------------------
// Bitmap word memory
// Single write port and single read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module bms_ram
  import bms_pkg::*;
#(
  parameter int DEPTH = NUM_WORDS_DEF,
  parameter int AW    = 12
) (
  input  wire          clk_i,
  input  wire          rd_en_i,
  input  wire [AW-1:0] rd_addr_i,
  output word_t        rd_data_o,
  input  wire          wr_en_i,
  input  wire [AW-1:0] wr_addr_i,
  input  word_t        wr_data_i
);

  word_t mem [DEPTH];
  word_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ----- hdl/bitmap_store_with_ack.sv -----
// ---------------------------------------------------------------------------
// Bitmap store with acknowledge
// A bitmap of NUM_WORDS 64-bit words with test, set, clear, flip and ack.
// ---------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Each result is shown
// for one cycle with result_strobe_o high and cannot be held off.
// After reset the block runs a clearing pass that writes zero to every word,
// one word a cycle, and holds busy high until the last word is written.
// Set, clear and flip perform a read-modify-write of one memory word and test
// reads one: busy is high for one cycle after the item is taken, so no new item
// is taken until that word is done. A test answer is registered from it.
// Ack reads and clears the masked bits of one word, then a shift unit scans
// the mask one bit position per cycle from bit 0 up to its highest set bit,
// emitting one index for each set bit. An ack keeps busy high until the scan
// has passed its highest set bit; a zero mask keeps it high for one cycle.
// Unused operation codes are taken and ignored without raising busy.
// ---------------------------------------------------------------------------
`default_nettype none
`include "bitmap_store_with_ack_defines.svh"

module bitmap_store_with_ack
  import bms_pkg::*;
#(
  parameter int NUM_WORDS = NUM_WORDS_DEF
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start,
  output logic              busy,
  input  wire  [FUNC_W-1:0] func_i,
  input  wire  [BIDX_W-1:0] bit_index_i,
  input  wire  [WIDX_W-1:0] word_index_i,
  input  wire  [WORD_W-1:0] ack_mask_i,
  output logic              result_strobe_o,
  output logic              result_kind_o,
  output logic              bit_value_o,
  output logic [BIDX_W-1:0] acked_index_o,
  output logic              last_o
);

  localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_MOD  = 2'd2;
  localparam logic [1:0] ST_ACK  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [FUNC_W-1:0] func_q, func_d;
  logic [WIDX_W-1:0] widx_q, widx_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  word_t             mask_q, mask_d;
  logic              ok_q, ok_d;

  logic              strobe_q, strobe_d;
  logic              kind_q, kind_d;
  logic              bval_q, bval_d;
  logic [BIDX_W-1:0] aidx_q, aidx_d;
  logic              last_q, last_d;

  logic              accept;
  logic              known_func;
  logic [WIDX_W-1:0] sel_word;
  logic              rd_en;
  word_t             rd_data;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  word_t             wr_data;
  word_t             bit_sel;
  word_t             mask_rest;

  assign known_func = (func_i == FUNC_TEST) || (func_i == FUNC_SET) ||
                      (func_i == FUNC_CLEAR) || (func_i == FUNC_FLIP) ||
                      (func_i == FUNC_ACK);
  assign accept     = start && (state_q == ST_IDLE);
  assign sel_word   = (func_i == FUNC_ACK) ? word_index_i : bit_index_i[BIDX_W-1:POS_W];
  assign rd_en      = accept && known_func;
  assign bit_sel    = word_t'(1) << pos_q;
  assign mask_rest  = mask_q >> 1;

  bms_ram #(
    .DEPTH(NUM_WORDS),
    .AW   (AW)
  ) u_ram (
    .clk_i    (clk_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(AW'(sel_word)),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    func_d   = func_q;
    widx_d   = widx_q;
    pos_d    = pos_q;
    mask_d   = mask_q;
    ok_d     = ok_q;
    strobe_d = 1'b0;
    kind_d   = kind_q;
    bval_d   = bval_q;
    aidx_d   = aidx_q;
    last_d   = last_q;
    wr_en    = 1'b0;
    wr_addr  = AW'(widx_q);
    wr_data  = rd_data;

    case (state_q)
      ST_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
        clr_d   = clr_q + AW'(1);
        if (clr_q == AW'(NUM_WORDS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && known_func) begin
          func_d  = func_i;
          widx_d  = sel_word;
          pos_d   = bit_index_i[POS_W-1:0];
          mask_d  = ack_mask_i;
          ok_d    = {20'b0, sel_word} < 32'(NUM_WORDS);
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        wr_en = ok_q && (func_q != FUNC_TEST);
        case (func_q)
          FUNC_SET:   wr_data = rd_data | bit_sel;
          FUNC_CLEAR: wr_data = rd_data & ~bit_sel;
          FUNC_FLIP:  wr_data = rd_data ^ bit_sel;
          FUNC_ACK:   wr_data = rd_data & ~mask_q;
          default:    wr_data = rd_data;
        endcase
        state_d = ST_IDLE;
        if (func_q == FUNC_TEST) begin
          strobe_d = 1'b1;
          kind_d   = 1'b0;
          bval_d   = ok_q && ((rd_data & bit_sel) != '0);
          aidx_d   = '0;
          last_d   = 1'b1;
        end else if ((func_q == FUNC_ACK) && (mask_q != '0)) begin
          pos_d   = '0;
          state_d = ST_ACK;
        end
      end
      ST_ACK: begin
        strobe_d = mask_q[0];
        kind_d   = 1'b1;
        bval_d   = 1'b0;
        aidx_d   = {widx_q, pos_q};
        last_d   = (mask_rest == '0);
        mask_d   = mask_rest;
        pos_d    = pos_q + POS_W'(1);
        if (mask_rest == '0) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLR;
      clr_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    widx_q <= widx_d;
    pos_q  <= pos_d;
    mask_q <= mask_d;
    ok_q   <= ok_d;
    kind_q <= kind_d;
    bval_q <= bval_d;
    aidx_q <= aidx_d;
    last_q <= last_d;
  end

  assign busy            = (state_q != ST_IDLE);
  assign result_strobe_o = strobe_q;
  assign result_kind_o   = kind_q;
  assign bit_value_o     = bval_q;
  assign acked_index_o   = aidx_q;
  assign last_o          = last_q;

  `BMS_ASSERT_SAME(a_test_is_last, result_strobe_o && !result_kind_o, last_o)
  `BMS_ASSERT_NEXT(a_test_sets_busy, start && !busy && (func_i == FUNC_TEST), busy)
  `BMS_ASSERT_NEXT(a_gap_after_last, result_strobe_o && last_o, !result_strobe_o)

endmodule

`default_nettype wire
